/* src/arvl_pkg.sv */
// arvl_pkg: shared constants, codes and types of the recency victim list
// depends on nothing; used by the interfaces and every module of the block
`default_nettype none

package arvl_pkg;

  localparam int DEPTH    = 32;
  localparam int KEY_BITS = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int OP_W     = 3;
  localparam int EV_W     = 2;
  localparam int ST_W     = 3;
  localparam int CHG_W    = 2;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // opcodes; query and the unused codes fall to the default arm
  localparam logic [OP_W-1:0] OP_ADD         = 3'd0;
  localparam logic [OP_W-1:0] OP_EVENT       = 3'd1;
  localparam logic [OP_W-1:0] OP_RECLAIM     = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_DEFAULT = 3'd3;

  // event codes; anything else is a non-foreground status
  localparam logic [EV_W-1:0] EV_STOP = 2'd0;
  localparam logic [EV_W-1:0] EV_FG   = 2'd1;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [ST_W-1:0] ST_PINNED    = 3'd4;

  localparam logic [CHG_W-1:0] CHG_NONE    = 2'd0;
  localparam logic [CHG_W-1:0] CHG_ADDED   = 2'd1;
  localparam logic [CHG_W-1:0] CHG_REMOVED = 2'd2;
  localparam logic [CHG_W-1:0] CHG_UPDATED = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_STOP,
    S_INSERT,
    S_FSCAN,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    POS_TAIL,
    POS_LAST_FG,
    POS_LAST_FG_ADJ
  } pos_sel_t;

  typedef struct packed {
    logic             latch;
    logic             scan_start;
    logic             scan_step;
    logic             stop_step;
    logic             ins_en;
    pos_sel_t         ins_pos;
    logic             ins_fg;
    logic             rem_en;
    logic             clr_fg;
    logic             set_default;
    logic             load;
    logic [ST_W-1:0]  status;
    logic [CHG_W-1:0] change;
    logic             victim;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [EV_W-1:0] ev;
    logic            add_fg;
    logic            critical;
    logic            scan_done;
    logic            found;
    logic            lf_valid;
    logic            idx_is_lf;
    logic            full;
    logic            empty;
    logic            head_fg;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/arvl_if.sv */
// arvl_if: valid/ready channels for command words and result words
// depends on arvl_pkg for field widths
`default_nettype none

interface arvl_req_if;
  logic                          valid;
  logic                          ready;
  logic [arvl_pkg::OP_W-1:0]     opcode;
  logic [arvl_pkg::KEY_BITS-1:0] app_key;
  logic [arvl_pkg::KEY_BITS-1:0] instance_key;
  logic                          add_foreground;
  logic [arvl_pkg::EV_W-1:0]     event_code;
  logic                          critical;

  modport source (
    output valid, opcode, app_key, instance_key, add_foreground, event_code, critical,
    input  ready
  );
  modport sink (
    input  valid, opcode, app_key, instance_key, add_foreground, event_code, critical,
    output ready
  );
endinterface

interface arvl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [arvl_pkg::ST_W-1:0]     result_status;
  logic [arvl_pkg::CHG_W-1:0]    change_kind;
  logic [arvl_pkg::KEY_BITS-1:0] victim_app;
  logic [arvl_pkg::KEY_BITS-1:0] victim_instance;
  logic [arvl_pkg::CNT_W-1:0]    entry_count;
  logic                          last_fg_valid;
  logic [arvl_pkg::KEY_BITS-1:0] last_fg_app;

  modport source (
    output valid, result_status, change_kind, victim_app, victim_instance, entry_count,
           last_fg_valid, last_fg_app,
    input  ready
  );
  modport sink (
    input  valid, result_status, change_kind, victim_app, victim_instance, entry_count,
           last_fg_valid, last_fg_app,
    output ready
  );
endinterface

`default_nettype wire

/* src/arvl_datapath.sv */
// arvl_datapath: entry list registers, scan pointer, shift insert/remove, result register
// depends on arvl_pkg
`default_nettype none

module arvl_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  arvl_pkg::dp_cmd_t             cmd,
  output arvl_pkg::dp_stat_t            stat,
  input  logic [arvl_pkg::OP_W-1:0]     opcode,
  input  logic [arvl_pkg::KEY_BITS-1:0] app_key,
  input  logic [arvl_pkg::KEY_BITS-1:0] instance_key,
  input  logic                          add_foreground,
  input  logic [arvl_pkg::EV_W-1:0]     event_code,
  input  logic                          critical,
  output logic [arvl_pkg::ST_W-1:0]     result_status,
  output logic [arvl_pkg::CHG_W-1:0]    change_kind,
  output logic [arvl_pkg::KEY_BITS-1:0] victim_app,
  output logic [arvl_pkg::KEY_BITS-1:0] victim_instance,
  output logic [arvl_pkg::CNT_W-1:0]    entry_count,
  output logic                          last_fg_valid,
  output logic [arvl_pkg::KEY_BITS-1:0] last_fg_app
);
  import arvl_pkg::*;

  key_t             ent_app  [DEPTH];
  key_t             ent_inst [DEPTH];
  logic [DEPTH-1:0] ent_fg;

  cnt_t count;
  cnt_t ptr;
  logic found;
  logic lf_valid;
  idx_t hit_idx;
  idx_t lf_idx;
  key_t lf_app;

  logic [OP_W-1:0] op_q;
  key_t            app_q;
  key_t            inst_q;
  logic            add_fg_q;
  logic [EV_W-1:0] ev_q;
  logic            crit_q;

  idx_t rd_idx;
  key_t rd_app;
  key_t rd_inst;
  logic rd_fg;
  logic rd_match;
  idx_t ins_pos;
  idx_t rem_pos;
  logic do_remove;

  // single scan read port
  assign rd_idx   = ptr[IDX_W-1:0];
  assign rd_app   = ent_app[rd_idx];
  assign rd_inst  = ent_inst[rd_idx];
  assign rd_fg    = ent_fg[rd_idx];
  assign rd_match = (rd_app == app_q) && (rd_inst == inst_q);

  always_comb begin
    unique case (cmd.ins_pos)
      POS_TAIL:        ins_pos = count[IDX_W-1:0];
      POS_LAST_FG:     ins_pos = lf_idx;
      // if the moved entry sat before the last foreground one, that one slid down by one
      POS_LAST_FG_ADJ: ins_pos = (hit_idx < lf_idx) ? lf_idx - 1'b1 : lf_idx;
      default:         ins_pos = count[IDX_W-1:0];
    endcase
  end

  assign rem_pos   = cmd.stop_step ? rd_idx : hit_idx;
  assign do_remove = cmd.rem_en || (cmd.stop_step && rd_match);

  // each position shifts from a fixed neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    localparam int PREV = (g == 0) ? 0 : g - 1;
    localparam int NEXT = (g == DEPTH - 1) ? g : g + 1;

    always_ff @(posedge clk) begin
      if (cmd.ins_en) begin
        if (IDX_W'(g) == ins_pos) begin
          ent_app[g]  <= app_q;
          ent_inst[g] <= inst_q;
          ent_fg[g]   <= cmd.ins_fg;
        end else if (IDX_W'(g) > ins_pos) begin
          ent_app[g]  <= ent_app[PREV];
          ent_inst[g] <= ent_inst[PREV];
          ent_fg[g]   <= ent_fg[PREV];
        end
      end else if (do_remove) begin
        if (IDX_W'(g) >= rem_pos) begin
          ent_app[g]  <= ent_app[NEXT];
          ent_inst[g] <= ent_inst[NEXT];
          ent_fg[g]   <= ent_fg[NEXT];
        end
      end else if (cmd.clr_fg) begin
        if (IDX_W'(g) == hit_idx) begin
          ent_fg[g] <= 1'b0;
        end
      end else if (cmd.set_default) begin
        ent_fg[g] <= (ent_app[g] == app_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ptr      <= '0;
      found    <= 1'b0;
      lf_valid <= 1'b0;
    end else begin
      if (cmd.ins_en) begin
        count <= count + 1'b1;
      end else if (do_remove) begin
        count <= count - 1'b1;
      end
      if (cmd.scan_start) begin
        ptr      <= '0;
        found    <= 1'b0;
        lf_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        ptr <= ptr + 1'b1;
        if (rd_match) begin
          found <= 1'b1;
        end
        if (rd_fg) begin
          lf_valid <= 1'b1;
        end
      end else if (cmd.stop_step && !rd_match) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && rd_match && !found) begin
      hit_idx <= rd_idx;
    end
    if (cmd.scan_step && rd_fg) begin
      lf_idx <= rd_idx;
      lf_app <= rd_app;
    end
    if (cmd.latch) begin
      op_q     <= opcode;
      app_q    <= app_key;
      inst_q   <= instance_key;
      add_fg_q <= add_foreground;
      ev_q     <= event_code;
      crit_q   <= critical;
    end
    if (cmd.load) begin
      result_status   <= cmd.status;
      change_kind     <= cmd.change;
      victim_app      <= cmd.victim ? ent_app[0] : '0;
      victim_instance <= cmd.victim ? ent_inst[0] : '0;
      entry_count     <= count;
      last_fg_valid   <= lf_valid;
      last_fg_app     <= lf_valid ? lf_app : '0;
    end
  end

  always_comb begin
    stat.op        = op_q;
    stat.ev        = ev_q;
    stat.add_fg    = add_fg_q;
    stat.critical  = crit_q;
    stat.scan_done = (ptr >= count);
    stat.found     = found;
    stat.lf_valid  = lf_valid;
    stat.idx_is_lf = (hit_idx == lf_idx);
    stat.full      = (count >= CNT_W'(DEPTH));
    stat.empty     = (count == '0);
    stat.head_fg   = ent_fg[0];
  end

endmodule

`default_nettype wire

/* src/arvl_ctrl.sv */
// arvl_ctrl: sequencer of scan, edit and result phases, output valid flag
// depends on arvl_pkg
`default_nettype none

module arvl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  arvl_pkg::dp_stat_t stat,
  output arvl_pkg::dp_cmd_t  cmd
);
  import arvl_pkg::*;

  state_t state;
  state_t state_next;

  logic [ST_W-1:0]  res_status;
  logic [CHG_W-1:0] res_change;
  logic             res_victim;
  pos_sel_t         pend_pos;
  logic             pend_fg;

  logic [ST_W-1:0]  dec_status;
  logic [CHG_W-1:0] dec_change;
  logic             dec_victim;
  pos_sel_t         dec_pos;
  logic             dec_fg;
  logic             can_load;

  assign can_load = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FSCAN;
        if (stat.op == OP_EVENT && stat.found) begin
          if (stat.ev == EV_STOP) begin
            state_next = S_STOP;
          end else if (stat.ev == EV_FG || !stat.lf_valid || !stat.idx_is_lf) begin
            state_next = S_INSERT;
          end
        end
      end
      S_STOP: begin
        if (stat.scan_done) begin
          state_next = S_FSCAN;
        end
      end
      S_INSERT: state_next = S_FSCAN;
      S_FSCAN: begin
        if (stat.scan_done) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    dec_status = ST_OK;
    dec_change = CHG_NONE;
    dec_victim = 1'b0;
    dec_pos    = POS_TAIL;
    dec_fg     = 1'b0;
    cmd.status = res_status;
    cmd.change = res_change;
    cmd.victim = res_victim;
    unique case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.latch      = in_valid;
        cmd.scan_start = in_valid;
      end
      S_SCAN: cmd.scan_step = !stat.scan_done;
      S_EXEC: begin
        cmd.scan_start = 1'b1;
        unique case (stat.op)
          OP_ADD: begin
            if (stat.full) begin
              dec_status = ST_FULL;
            end else begin
              cmd.ins_en  = 1'b1;
              cmd.ins_pos = (stat.add_fg || !stat.lf_valid) ? POS_TAIL : POS_LAST_FG;
              cmd.ins_fg  = stat.add_fg;
              dec_change  = CHG_ADDED;
            end
          end
          OP_EVENT: begin
            if (!stat.found) begin
              dec_status = ST_NOT_FOUND;
            end else if (stat.ev == EV_STOP) begin
              dec_change = CHG_REMOVED;
            end else if (stat.ev == EV_FG) begin
              cmd.rem_en = 1'b1;
              dec_fg     = 1'b1;
              dec_change = CHG_UPDATED;
            end else begin
              dec_change = CHG_UPDATED;
              if (!stat.lf_valid) begin
                cmd.rem_en = 1'b1;
              end else if (stat.idx_is_lf) begin
                cmd.clr_fg = 1'b1;
              end else begin
                cmd.rem_en = 1'b1;
                dec_pos    = POS_LAST_FG_ADJ;
              end
            end
          end
          OP_RECLAIM: begin
            if (stat.empty) begin
              dec_status = ST_EMPTY;
            end else if (stat.head_fg && !stat.critical) begin
              dec_status = ST_PINNED;
            end else begin
              dec_victim = 1'b1;
            end
          end
          OP_SET_DEFAULT: cmd.set_default = 1'b1;
          default: ;
        endcase
      end
      S_STOP: begin
        cmd.stop_step  = !stat.scan_done;
        cmd.scan_start = stat.scan_done;
      end
      S_INSERT: begin
        cmd.ins_en     = 1'b1;
        cmd.ins_pos    = pend_pos;
        cmd.ins_fg     = pend_fg;
        cmd.scan_start = 1'b1;
      end
      S_FSCAN: cmd.scan_step = !stat.scan_done;
      S_RESULT: cmd.load = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      res_status <= dec_status;
      res_change <= dec_change;
      res_victim <= dec_victim;
      pend_pos   <= dec_pos;
      pend_fg    <= dec_fg;
    end
  end

endmodule

`default_nettype wire

/* src/app_recency_victim_list_unit.sv */
// app_recency_victim_list_unit: top level of the recency victim list
// depends on arvl_pkg, arvl_if, arvl_ctrl and arvl_datapath
`default_nettype none

//  channel | dir | word                                      | accepted when
//  --------+-----+-------------------------------------------+--------------------
//  req     | in  | opcode, keys, add_foreground, event, crit | req.valid & req.ready
//  rsp     | out | status, change, victim, count, last fg    | rsp.valid & rsp.ready
//
// one command word gives exactly one result word; commands are taken one at a time
// the list is walked once before and once after the edit through a single scan read
// port, one entry per cycle; a moved entry is inserted in its own step after the edit,
// and a stop event adds a compaction pass that removes every matching entry
// insert and remove are parallel shifts of the list; flag rewrites are done in place
// rst (synchronous) empties the list; entry contents are not cleared
// the result sits in an output register, so a stalled rsp holds the word while
// the next command is taken; only a second finished result waits for rsp

module app_recency_victim_list_unit (
  input  logic       clk,
  input  logic       rst,
  arvl_req_if.sink   req,
  arvl_rsp_if.source rsp
);
  import arvl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: scan, edit, rescan, publish
  arvl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // list storage and result register
  arvl_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .opcode          (req.opcode),
    .app_key         (req.app_key),
    .instance_key    (req.instance_key),
    .add_foreground  (req.add_foreground),
    .event_code      (req.event_code),
    .critical        (req.critical),
    .result_status   (rsp.result_status),
    .change_kind     (rsp.change_kind),
    .victim_app      (rsp.victim_app),
    .victim_instance (rsp.victim_instance),
    .entry_count     (rsp.entry_count),
    .last_fg_valid   (rsp.last_fg_valid),
    .last_fg_app     (rsp.last_fg_app)
  );

endmodule

`default_nettype wire
